// ----- rtl/wms_pkg.sv -----
package wms_pkg;

  // Fixed field widths of the sample and result beats.
  localparam int SAMPLE_W = 24;
  localparam int MEAN_W   = 32;
  localparam int STDEV_W  = 32;

  // Results carry 8 fractional bits; the radicand needs twice as many.
  localparam int FRAC_W      = 8;
  localparam int ROOT_FRAC_W = 2 * FRAC_W;

  // Default window length and depth of the queue between front and back.
  localparam int DEF_WINDOW_DEPTH = 16;
  localparam int QUEUE_DEPTH      = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEAN_W-1:0]   mean_t;
  typedef logic        [STDEV_W-1:0]  stdev_t;

  // Status of the queue as seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- rtl/wms_queue.sv -----
module wms_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output wms_pkg::qstat_t  stat
);
  import wms_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign dout       = mem_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/wms_front.sv -----
module wms_front #(
  parameter  int WINDOW_DEPTH = wms_pkg::DEF_WINDOW_DEPTH,
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH),
  localparam int SUM_W        = wms_pkg::SAMPLE_W + SLOT_W,
  localparam int SQ_W         = 2 * wms_pkg::SAMPLE_W - 1 + SLOT_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  wms_pkg::sample_t        in_sample,
  output logic                    in_full,
  input  wms_pkg::qstat_t         q_stat,
  output logic                    q_push,
  output logic [SUM_W+SQ_W-1:0]   q_din
);
  import wms_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int MAG_W  = 2 * SAMPLE_W - 1;

  // Sample ring and one valid bit per slot, so unwritten slots read as zero.
  sample_t                  ring_r [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]  slot_vld_r;
  sample_t                  old_rd_r;
  logic                     old_vld_r;

  logic                     hold_r;
  sample_t                  smp_r;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]          sumsq_r, sumsq_nxt;

  logic                     accept;
  logic                     retire;
  sample_t                  old_smp;
  logic signed [PROD_W-1:0] sq_new;
  logic signed [PROD_W-1:0] sq_old;

  // A beat is taken when no earlier sample is still held for retiring into the queue.
  assign in_full = hold_r;
  assign accept  = in_push && !hold_r;
  assign retire  = hold_r && !q_stat.full;

  // Running sums: add the new sample and drop the one it overwrites.
  always_comb begin
    old_smp   = old_vld_r ? old_rd_r : '0;
    sq_new    = PROD_W'(smp_r) * PROD_W'(smp_r);
    sq_old    = PROD_W'(old_smp) * PROD_W'(old_smp);
    sum_nxt   = sum_r + SUM_W'(smp_r) - SUM_W'(old_smp);
    sumsq_nxt = sumsq_r + SQ_W'(sq_new[MAG_W-1:0]) - SQ_W'(sq_old[MAG_W-1:0]);
    slot_nxt  = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
  end

  assign q_push = retire;
  assign q_din  = {sum_nxt, sumsq_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r     <= 1'b0;
      slot_r     <= '0;
      sum_r      <= '0;
      sumsq_r    <= '0;
      slot_vld_r <= '0;
    end else begin
      if (accept) begin
        hold_r <= 1'b1;
      end else if (retire) begin
        hold_r <= 1'b0;
      end
      if (retire) begin
        slot_r             <= slot_nxt;
        sum_r              <= sum_nxt;
        sumsq_r            <= sumsq_nxt;
        slot_vld_r[slot_r] <= 1'b1;
      end
    end
  end

  // Ring memory: read the slot about to be overwritten, write it on retire.
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r     <= in_sample;
      old_rd_r  <= ring_r[slot_r];
      old_vld_r <= slot_vld_r[slot_r];
    end
    if (retire) begin
      ring_r[slot_r] <= smp_r;
    end
  end

endmodule

// ----- rtl/wms_sqrt.sv -----
module wms_sqrt #(
  parameter int ROOT_W = 36
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  busy,
  output logic [ROOT_W-1:0]     root
);

  localparam int REM_W = ROOT_W + 1;
  localparam int CUR_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;

  logic [CUR_W-1:0]    cur;
  logic [CUR_W-1:0]    trial;
  logic                fits;
  logic [CUR_W-1:0]    diff;

  assign busy = busy_r;
  assign root = root_r;

  // One result bit per cycle: bring down two radicand bits, try 4*root+1.
  always_comb begin
    cur   = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
    trial = CUR_W'({root_r, 2'b01});
    fits  = (cur >= trial);
    diff  = cur - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(ROOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[2*ROOT_W-3:0], 2'b00};
      rem_r  <= fits ? diff[REM_W-1:0] : cur[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/wms_div.sv -----
module wms_div #(
  parameter int DIVISOR = 16,
  parameter int WIDTH   = 36
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  output logic             busy,
  output logic [WIDTH-1:0] quot,
  output logic             rem_nz
);

  localparam int  DV_W    = $clog2(DIVISOR);
  localparam bit  IS_POW2 = (DIVISOR == (1 << DV_W));
  localparam int  CNT_W   = $clog2(WIDTH + 1);

  logic             busy_r;
  logic [WIDTH-1:0] quot_r;

  assign busy = busy_r;
  assign quot = quot_r;

  if (IS_POW2) begin : g_shift
    logic nz_r;

    assign rem_nz = nz_r;

    // Power-of-two window: the quotient is a shift, the remainder a mask.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
      end else begin
        busy_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        quot_r <= dividend >> DV_W;
        nz_r   <= |dividend[DV_W-1:0];
      end
    end
  end else begin : g_recip
    localparam int CH_W = 16;
    localparam int NCH  = (WIDTH + CH_W - 1) / CH_W;
    localparam int X_W  = NCH * CH_W;
    localparam int S_W  = WIDTH + DV_W;
    localparam int M_W  = WIDTH + 2;
    localparam int PP_W = CH_W + M_W;
    localparam int P_W  = 2 * WIDTH + DV_W + 2;
    localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << S_W) / 64'(DIVISOR)) + 64'd1);

    logic [X_W-1:0]   x_r;
    logic [P_W-1:0]   acc_r;
    logic [CNT_W-1:0] cnt_r;
    logic             nz_r;
    logic [PP_W-1:0]  part;
    logic [P_W-1:0]   acc_nxt;

    assign rem_nz = nz_r;

    // Multiply by the rounded-up reciprocal of N, one 16-bit slice of the
    // dividend per cycle, most significant slice first.
    always_comb begin
      part    = PP_W'(x_r[X_W-1 -: CH_W]) * PP_W'(RECIP);
      acc_nxt = (acc_r << CH_W) + P_W'(part);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        cnt_r  <= '0;
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NCH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end

    // The quotient sits from bit S_W of the product up. The remainder is
    // nonzero exactly when the bits below reach the reciprocal.
    always_ff @(posedge clk) begin
      if (start) begin
        x_r   <= X_W'(dividend);
        acc_r <= '0;
      end else if (busy_r) begin
        x_r   <= x_r << CH_W;
        acc_r <= acc_nxt;
        if (cnt_r == CNT_W'(1)) begin
          quot_r <= acc_nxt[S_W +: WIDTH];
          nz_r   <= (acc_nxt[S_W-1:0] >= S_W'(RECIP));
        end
      end
    end
  end

endmodule

// ----- rtl/wms_back.sv -----
module wms_back #(
  parameter  int WINDOW_DEPTH = wms_pkg::DEF_WINDOW_DEPTH,
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH),
  localparam int SUM_W        = wms_pkg::SAMPLE_W + SLOT_W,
  localparam int SQ_W         = 2 * wms_pkg::SAMPLE_W - 1 + SLOT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wms_pkg::qstat_t       q_stat,
  input  logic [SUM_W+SQ_W-1:0] q_dout,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output wms_pkg::mean_t        out_mean_q8,
  output wms_pkg::stdev_t       out_stdev_q8
);
  import wms_pkg::*;

  localparam int D_W    = 2 * SUM_W;
  localparam int ROOT_W = SUM_W + FRAC_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQR  = 6'b000010,
    S_DIFF = 6'b000100,
    S_ROOT = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    out_vld_r, out_vld_nxt;
  mean_t                   mean_r;
  stdev_t                  stdev_r;

  logic signed [SUM_W-1:0] head_sum;
  logic [SQ_W-1:0]         head_sumsq;
  logic [SUM_W-1:0]        abs_r;
  logic                    neg_r;
  logic [SQ_W-1:0]         sumsq_r;
  logic [D_W-1:0]          sq_r;
  logic [D_W-1:0]          nsq_r;
  logic [D_W-1:0]          disp;

  logic                    load;
  logic                    sqrt_start;
  logic                    rdiv_start;
  logic                    emit;
  logic                    sqrt_busy;
  logic [ROOT_W-1:0]       root;
  logic                    mdiv_busy;
  logic [ROOT_W-1:0]       mdiv_q;
  logic                    mdiv_nz;
  logic                    rdiv_busy;
  logic [ROOT_W-1:0]       rdiv_q;
  logic                    rdiv_nz;
  logic [ROOT_W-1:0]       mean_mag;
  logic [ROOT_W-1:0]       mean_full;

  assign {head_sum, head_sumsq} = q_dout;
  assign disp = nsq_r - sq_r;

  // Sequencer: load sums, square, form N*sumsq - sum^2, root, divide, emit.
  always_comb begin
    state_nxt  = state_r;
    load       = 1'b0;
    sqrt_start = 1'b0;
    rdiv_start = 1'b0;
    emit       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          load      = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        sqrt_start = 1'b1;
        state_nxt  = S_ROOT;
      end
      S_ROOT: begin
        if (!sqrt_busy) begin
          rdiv_start = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (!rdiv_busy && !mdiv_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_vld_r || out_pop) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign q_pop = load;

  // Output register holds one result beat until it is popped.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Operand registers: magnitude of the sum, then the two wide products.
  always_ff @(posedge clk) begin
    if (load) begin
      neg_r   <= head_sum[SUM_W-1];
      abs_r   <= head_sum[SUM_W-1] ? SUM_W'(-head_sum) : SUM_W'(head_sum);
      sumsq_r <= head_sumsq;
    end
    if (state_r == S_SQR) begin
      sq_r  <= D_W'(abs_r) * D_W'(abs_r);
      nsq_r <= D_W'(sumsq_r) * D_W'(WINDOW_DEPTH);
    end
  end

  wms_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({disp, ROOT_FRAC_W'(0)}),
    .busy     (sqrt_busy),
    .root     (root)
  );

  // The mean divide runs alongside the root.
  wms_div #(
    .DIVISOR (WINDOW_DEPTH),
    .WIDTH   (ROOT_W)
  ) u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .dividend ({abs_r, FRAC_W'(0)}),
    .busy     (mdiv_busy),
    .quot     (mdiv_q),
    .rem_nz   (mdiv_nz)
  );

  wms_div #(
    .DIVISOR (WINDOW_DEPTH),
    .WIDTH   (ROOT_W)
  ) u_root_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rdiv_start),
    .dividend (root),
    .busy     (rdiv_busy),
    .quot     (rdiv_q),
    .rem_nz   (rdiv_nz)
  );

  // A negative mean rounds away from zero in magnitude to floor it.
  always_comb begin
    mean_mag  = mdiv_q + ROOT_W'(mdiv_nz);
    mean_full = neg_r ? (~mean_mag + ROOT_W'(1)) : mdiv_q;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mean_r  <= mean_t'(mean_full[MEAN_W-1:0]);
      stdev_r <= stdev_t'(rdiv_q[STDEV_W-1:0]);
    end
  end

  assign out_empty    = !out_vld_r;
  assign out_mean_q8  = mean_r;
  assign out_stdev_q8 = stdev_r;

endmodule

// ----- rtl/window_mean_stdev.sv -----
// Sliding-window mean and population standard deviation of signed 24-bit
// samples over the last WINDOW_DEPTH beats (the window starts out as zeros),
// both as Q8 fixed point and floored. The front takes a sample, updates the
// running sum and sum of squares and queues them, and takes no new sample
// until the previous one is queued; the back takes one item at a time, forms
// N*sumsq - sum^2 and takes a bit-serial square root of it, one bit per
// cycle, which sets the sustained rate. With a power-of-two window the back
// divides by N with a shift and a mask; other windows divide by N through a
// multiply with its reciprocal, 16 bits per cycle.
// A two-entry queue and the output register let both sides stall on their own.
module window_mean_stdev #(
  parameter int WINDOW_DEPTH = wms_pkg::DEF_WINDOW_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  wms_pkg::sample_t in_sample,
  output logic             in_full,
  input  logic             out_pop,
  output logic             out_empty,
  output wms_pkg::mean_t   out_mean_q8,
  output wms_pkg::stdev_t  out_stdev_q8
);
  import wms_pkg::*;

  localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
  localparam int SUM_W   = SAMPLE_W + SLOT_W;
  localparam int SQ_W    = 2 * SAMPLE_W - 1 + SLOT_W;
  localparam int ENTRY_W = SUM_W + SQ_W;

  qstat_t             q_stat;
  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_din;
  logic [ENTRY_W-1:0] q_dout;

  wms_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_full   (in_full),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  wms_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  wms_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_dout       (q_dout),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_mean_q8  (out_mean_q8),
    .out_stdev_q8 (out_stdev_q8)
  );

endmodule
